>>> rtl/iqgq_pkg.sv
// ----------------------------------------------------------------------------
// iqgq_pkg
// shared types and constants for the iq gain quantizer with clip statistics
// ----------------------------------------------------------------------------
package iqgq_pkg;

    // output format codes
    typedef logic [1:0] t_out_format;
    localparam t_out_format FMT_INT32 = 2'd0;
    localparam t_out_format FMT_INT16 = 2'd1;
    localparam t_out_format FMT_INT8  = 2'd2;

    // configuration register indexes
    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_OUT_FORMAT  = 2'd0;
    localparam t_cfg_index CFG_GAIN        = 2'd1;
    localparam t_cfg_index CFG_TRACK_CLIPS = 2'd2;

    // register reset values
    localparam t_out_format RST_OUT_FORMAT = FMT_INT16;
    localparam logic [15:0] RST_GAIN       = 16'd4096;

    // fixed point limits, Q3.28
    localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;
    localparam logic [30:0] Q_ONE   = 31'h1000_0000;

    // full scale exponents, full scale is 2^k-1
    localparam int FS_BITS_INT32 = 31;
    localparam int FS_BITS_INT16 = 15;
    localparam int FS_BITS_INT8  = 7;

    // one gained component: sign and saturated magnitude
    typedef struct packed {
        logic        neg;
        logic [30:0] mag;
    } t_gained;

endpackage

>>> rtl/iq_gain_quantizer_with_clip_stats_core.sv
// ----------------------------------------------------------------------------
// iq_gain_quantizer_with_clip_stats_core
// gain, saturation and integer quantization of iq samples with clip stats
// ----------------------------------------------------------------------------
// Input channel i_valid / o_stall carries one complex Q3.28 sample and a
// block end mark per transfer. Output channel o_valid / i_stall returns one
// result per sample: both quantized parts, the running peak magnitude, the
// clip count and the component count as they stand after that sample.
// The block is a three-register pipeline: input register, gain register
// (one 32x16 multiply per part), result register. A sample passes the
// input, gain and result registers in that order before o_valid shows its
// result; throughput is one sample per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and earlier stages
// keep filling until each holds an item; o_stall rises only then, so bubbles
// are squeezed out. Configuration writes on i_cfg_valid / o_cfg_ready are
// always taken, as o_cfg_ready is tied high, and are meant for idle periods.
// Reset empties the pipeline, clears peak and both counters, and sets the
// format to int16, gain to 4096 and clip tracking off.
// ----------------------------------------------------------------------------
module iq_gain_quantizer_with_clip_stats_core #(
    parameter int COUNT_WIDTH    = 48,
    parameter int GAIN_FRAC_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [31:0]     i_sample_re,
    input  logic signed [31:0]     i_sample_im,
    input  logic                   i_block_end,
    // output channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [31:0]     o_quant_re,
    output logic signed [31:0]     o_quant_im,
    output logic [30:0]            o_peak_magnitude,
    output logic [COUNT_WIDTH-1:0] o_clipped_count,
    output logic [COUNT_WIDTH-1:0] o_component_count,
    output logic                   o_block_end_out,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [15:0]            i_cfg_data
);

    // configuration
    iqgq_pkg::t_out_format r_out_format;
    logic [15:0]           r_gain;
    logic                  r_track_clips;

    // pipeline
    logic                  r_v1, r_v2, r_v3;
    logic signed [31:0]    r_re1, r_im1;
    logic                  r_be1, r_be2;
    iqgq_pkg::t_gained     r_g_re, r_g_im;
    logic signed [31:0]    r_q_re, r_q_im;
    logic                  r_be3;

    // statistics
    logic [30:0]            r_peak;
    logic [COUNT_WIDTH-1:0] r_clip;
    logic [COUNT_WIDTH-1:0] r_comp;

    logic en1, en2, en3;
    iqgq_pkg::t_gained g_re, g_im;
    logic [30:0]            n_peak;
    logic [COUNT_WIDTH-1:0] n_clip, n_comp;
    logic [COUNT_WIDTH:0]   clip_sum, comp_sum;
    logic [1:0]             clip_inc;
    logic [30:0]            m_big;
    logic signed [31:0]     n_q_re, n_q_im;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_format  <= iqgq_pkg::RST_OUT_FORMAT;
            r_gain        <= iqgq_pkg::RST_GAIN;
            r_track_clips <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                iqgq_pkg::CFG_OUT_FORMAT:  r_out_format  <= i_cfg_data[1:0];
                iqgq_pkg::CFG_GAIN:        r_gain        <= i_cfg_data;
                iqgq_pkg::CFG_TRACK_CLIPS: r_track_clips <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage enables, a stage loads when it is empty or its successor moves
    assign en3     = !r_v3 || !i_stall;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_re1 <= i_sample_re;
            r_im1 <= i_sample_im;
            r_be1 <= i_block_end;
        end
        if (en2) begin
            r_g_re <= g_re;
            r_g_im <= g_im;
            r_be2  <= r_be1;
        end
        if (en3) begin
            r_q_re <= n_q_re;
            r_q_im <= n_q_im;
            r_be3  <= r_be2;
        end
    end

    iqgq_gain #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_gain_re (
        .i_sample (r_re1),
        .i_gain   (r_gain),
        .o_gained (g_re)
    );

    iqgq_gain #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_gain_im (
        .i_sample (r_im1),
        .i_gain   (r_gain),
        .o_gained (g_im)
    );

    // clamp to 1.0, scale by 2^k-1 as shift and subtract, truncate toward zero
    function automatic logic signed [31:0] quantize(
        input iqgq_pkg::t_gained     g,
        input iqgq_pkg::t_out_format fmt
    );
        logic [28:0] cm;
        logic [59:0] base;
        logic [59:0] full;
        logic [31:0] q;
        cm   = (g.mag > iqgq_pkg::Q_ONE) ? iqgq_pkg::Q_ONE[28:0] : g.mag[28:0];
        base = {31'd0, cm};
        case (fmt)
            iqgq_pkg::FMT_INT32: full = (base << iqgq_pkg::FS_BITS_INT32) - base;
            iqgq_pkg::FMT_INT16: full = (base << iqgq_pkg::FS_BITS_INT16) - base;
            default:             full = (base << iqgq_pkg::FS_BITS_INT8) - base;
        endcase
        q = full[59:28];
        return g.neg ? (32'd0 - q) : q;
    endfunction

    always_comb begin
        n_q_re = quantize(r_g_re, r_out_format);
        n_q_im = quantize(r_g_im, r_out_format);

        m_big  = (r_g_re.mag > r_g_im.mag) ? r_g_re.mag : r_g_im.mag;
        n_peak = (m_big > r_peak) ? m_big : r_peak;

        // counters hold at all ones; a carry out means saturation
        comp_sum = {1'b0, r_comp} + (COUNT_WIDTH+1)'(2);
        n_comp   = comp_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : comp_sum[COUNT_WIDTH-1:0];

        clip_inc = {1'b0, r_g_re.mag > iqgq_pkg::Q_ONE}
                 + {1'b0, r_g_im.mag > iqgq_pkg::Q_ONE};
        clip_sum = {1'b0, r_clip} + {{(COUNT_WIDTH-1){1'b0}}, clip_inc};
        if (!r_track_clips) begin
            n_clip = r_clip;
        end else if (clip_sum[COUNT_WIDTH]) begin
            n_clip = {COUNT_WIDTH{1'b1}};
        end else begin
            n_clip = clip_sum[COUNT_WIDTH-1:0];
        end
    end

    // statistics advance as the result register takes the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
            r_clip <= '0;
            r_comp <= '0;
        end else if (en3 && r_v2) begin
            r_peak <= n_peak;
            r_clip <= n_clip;
            r_comp <= n_comp;
        end
    end

    assign o_valid           = r_v3;
    assign o_quant_re        = r_q_re;
    assign o_quant_im        = r_q_im;
    assign o_block_end_out   = r_be3;
    assign o_peak_magnitude  = r_peak;
    assign o_clipped_count   = r_clip;
    assign o_component_count = r_comp;

endmodule

>>> rtl/iqgq_gain.sv
// ----------------------------------------------------------------------------
// iqgq_gain
// applies the unsigned gain to one signed Q3.28 component, floor and saturate
// ----------------------------------------------------------------------------
module iqgq_gain #(
    parameter int GAIN_FRAC_BITS = 12
) (
    input  logic signed [31:0] i_sample,
    input  logic        [15:0] i_gain,
    output iqgq_pkg::t_gained  o_gained
);

    localparam int PW = 49;

    logic        sign;
    logic [31:0] mag_in;
    logic [47:0] prod;
    logic [PW-1:0] biased;
    logic [PW-1:0] scaled;
    logic [30:0] mag_out;

    always_comb begin
        sign   = i_sample[31];
        mag_in = sign ? (~i_sample + 32'd1) : i_sample;
        prod   = {16'd0, mag_in} * {32'd0, i_gain};
        // negative parts round up in magnitude so the signed result floors
        biased = sign ? ({1'b0, prod} + {{(PW-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}})
                      : {1'b0, prod};
        scaled = biased >> GAIN_FRAC_BITS;
        if (scaled > {{(PW-31){1'b0}}, iqgq_pkg::MAG_MAX}) begin
            mag_out = iqgq_pkg::MAG_MAX;
        end else begin
            mag_out = scaled[30:0];
        end
        o_gained.mag = mag_out;
        o_gained.neg = sign && (mag_out != 31'd0);
    end

endmodule

>>> rtl/iqgq_checker.sv
// ----------------------------------------------------------------------------
// iqgq_checker
// port level checks for the iq gain quantizer, attached by bind
// ----------------------------------------------------------------------------
module iqgq_checker #(
    parameter int COUNT_WIDTH = 48
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic signed [31:0]     o_quant_re,
    input logic signed [31:0]     o_quant_im,
    input logic [30:0]            o_peak_magnitude,
    input logic [COUNT_WIDTH-1:0] o_clipped_count,
    input logic [COUNT_WIDTH-1:0] o_component_count,
    input logic                   o_block_end_out
);

    logic                   r_seen;
    logic [30:0]            r_last_peak;
    logic [COUNT_WIDTH-1:0] r_last_comp;
    logic                   out_xfer;

    assign out_xfer = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_last_peak <= '0;
            r_last_comp <= '0;
        end else if (out_xfer) begin
            r_seen      <= 1'b1;
            r_last_peak <= o_peak_magnitude;
            r_last_comp <= o_component_count;
        end
    end

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_quant_re) && $stable(o_quant_im)
            && $stable(o_component_count) && $stable(o_block_end_out))
        else $error("stalled result changed");

    // the peak never falls between results
    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_seen |-> o_peak_magnitude >= r_last_peak)
        else $error("peak magnitude decreased");

    // the component count rises with each result until it saturates (the core adds two)
    a_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_seen |-> o_component_count > r_last_comp
            || o_component_count == {COUNT_WIDTH{1'b1}})
        else $error("component count did not advance");

    // clipped components are a subset of all components
    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_clipped_count <= o_component_count)
        else $error("clip count above component count");

    // quantized values are symmetric, most negative code never appears
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_quant_re != 32'sh8000_0000 && o_quant_im != 32'sh8000_0000)
        else $error("quantized value out of range");

endmodule

bind iq_gain_quantizer_with_clip_stats_core iqgq_checker #(
    .COUNT_WIDTH(COUNT_WIDTH)
) u_iqgq_checker (.*);

>>> tb/tb_iq_gain_quantizer_with_clip_stats_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_iq_gain_quantizer_with_clip_stats_core
// self-checking bench for the iq gain quantizer with clip statistics
// ----------------------------------------------------------------------------
// A scoreboard class predicts every result when its sample transfer is seen:
// gain with floor and saturation, clamp to 1.0, scaling per output format,
// running peak and the two saturating counters. A short directed run covers
// the edges of the Q3.28 range and the 1.0 boundary; then phases of random
// samples run under different format, gain and tracking settings, with
// register writes only while the pipeline is empty. Both sides insert random
// idle cycles, and the receiver twice holds off long enough to back up the
// pipeline into the input stall.
// ----------------------------------------------------------------------------
module tb_iq_gain_quantizer_with_clip_stats_core;

    localparam int CNT_W      = 48;
    localparam int GAIN_FRAC  = 12;
    localparam int Q_FRAC     = 28;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_OFF   = 120;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    // codes the package leaves unnamed
    localparam iqgq_pkg::t_out_format FMT_UNUSED = 2'd3;
    localparam iqgq_pkg::t_cfg_index  CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [31:0]      re;
        logic [31:0]      im;
        logic [30:0]      peak;
        logic [CNT_W-1:0] clips;
        logic [CNT_W-1:0] comps;
        logic             last;
    } t_iq_result;

    class iq_quant_scoreboard;
        iqgq_pkg::t_out_format fmt;
        logic [15:0]           gain_q412;
        logic                  track;
        logic [30:0]           peak;
        logic [CNT_W-1:0]      clip_total;
        logic [CNT_W-1:0]      comp_total;
        t_iq_result            awaited_q[$];
        int                    errors;

        function new();
            fmt        = iqgq_pkg::RST_OUT_FORMAT;
            gain_q412  = iqgq_pkg::RST_GAIN;
            track      = 1'b0;
            peak       = '0;
            clip_total = '0;
            comp_total = '0;
            errors     = 0;
        endfunction

        function void write_reg(iqgq_pkg::t_cfg_index idx, logic [15:0] data);
            case (idx)
                iqgq_pkg::CFG_OUT_FORMAT:  fmt = data[1:0];
                iqgq_pkg::CFG_GAIN:        gain_q412 = data;
                iqgq_pkg::CFG_TRACK_CLIPS: track = data[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        function logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] c, int unsigned inc);
            logic [CNT_W:0] s;
            s = c + inc;
            return (s > CNT_MAX) ? CNT_MAX : s[CNT_W-1:0];
        endfunction

        // magnitude times gain, floor toward minus infinity, saturate
        function iqgq_pkg::t_gained gain_part(logic [31:0] raw);
            logic [63:0]       mag;
            logic [63:0]       prod;
            logic [63:0]       r;
            iqgq_pkg::t_gained g;
            mag  = raw[31] ? (64'h1_0000_0000 - raw) : 64'(raw);
            prod = mag * gain_q412;
            if (raw[31])
                r = (prod + ((64'd1 << GAIN_FRAC) - 1)) >> GAIN_FRAC;
            else
                r = prod >> GAIN_FRAC;
            if (r > iqgq_pkg::MAG_MAX)
                r = 64'(iqgq_pkg::MAG_MAX);
            g.mag = r[30:0];
            g.neg = raw[31] && (r != 0);
            return g;
        endfunction

        function logic [31:0] quantize_part(iqgq_pkg::t_gained g);
            logic [63:0] fs;
            logic [63:0] m;
            logic [63:0] q;
            case (fmt)
                iqgq_pkg::FMT_INT32: fs = (64'd1 << iqgq_pkg::FS_BITS_INT32) - 1;
                iqgq_pkg::FMT_INT16: fs = (64'd1 << iqgq_pkg::FS_BITS_INT16) - 1;
                default:             fs = (64'd1 << iqgq_pkg::FS_BITS_INT8) - 1;
            endcase
            m = (g.mag > iqgq_pkg::Q_ONE) ? 64'(iqgq_pkg::Q_ONE) : 64'(g.mag);
            q = (m * fs) >> Q_FRAC;
            if (g.neg)
                q = -q;
            return q[31:0];
        endfunction

        function void note_sample(logic [31:0] re, logic [31:0] im, logic last);
            iqgq_pkg::t_gained gr;
            iqgq_pkg::t_gained gi;
            logic [30:0]       big;
            t_iq_result        e;
            gr  = gain_part(re);
            gi  = gain_part(im);
            big = (gr.mag > gi.mag) ? gr.mag : gi.mag;
            if (big > peak)
                peak = big;
            comp_total = sat_add(comp_total, 2);
            if (track)
                clip_total = sat_add(clip_total,
                                     int'(gr.mag > iqgq_pkg::Q_ONE)
                                     + int'(gi.mag > iqgq_pkg::Q_ONE));
            e.re    = quantize_part(gr);
            e.im    = quantize_part(gi);
            e.peak  = peak;
            e.clips = clip_total;
            e.comps = comp_total;
            e.last  = last;
            awaited_q.push_back(e);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_iq_result got);
            t_iq_result e;
            if (awaited_q.size() == 0) begin
                report("result with no sample outstanding");
                return;
            end
            e = awaited_q.pop_front();
            if (got.re !== e.re)
                report($sformatf("quant_re %h, expected %h", got.re, e.re));
            if (got.im !== e.im)
                report($sformatf("quant_im %h, expected %h", got.im, e.im));
            if (got.peak !== e.peak)
                report($sformatf("peak_magnitude %h, expected %h", got.peak, e.peak));
            if (got.clips !== e.clips)
                report($sformatf("clipped_count %0d, expected %0d", got.clips, e.clips));
            if (got.comps !== e.comps)
                report($sformatf("component_count %0d, expected %0d", got.comps, e.comps));
            if (got.last !== e.last)
                report($sformatf("block_end_out %b, expected %b", got.last, e.last));
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic signed [31:0]      i_sample_re;
    logic signed [31:0]      i_sample_im;
    logic                    i_block_end;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [31:0]      o_quant_re;
    logic signed [31:0]      o_quant_im;
    logic [30:0]             o_peak_magnitude;
    logic [CNT_W-1:0]        o_clipped_count;
    logic [CNT_W-1:0]        o_component_count;
    logic                    o_block_end_out;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [1:0]              i_cfg_index;
    logic [15:0]             i_cfg_data;

    iq_quant_scoreboard sb = new();
    logic               gapless = 1'b0;
    int                 results_seen = 0;
    int                 idle_cycles = 0;

    iq_gain_quantizer_with_clip_stats_core #(
        .COUNT_WIDTH    (CNT_W),
        .GAIN_FRAC_BITS (GAIN_FRAC)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_sample_re       (i_sample_re),
        .i_sample_im       (i_sample_im),
        .i_block_end       (i_block_end),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_quant_re        (o_quant_re),
        .o_quant_im        (o_quant_im),
        .o_peak_magnitude  (o_peak_magnitude),
        .o_clipped_count   (o_clipped_count),
        .o_component_count (o_component_count),
        .o_block_end_out   (o_block_end_out),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    task cfg_write(iqgq_pkg::t_cfg_index idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    task send_sample(logic [31:0] re, logic [31:0] im, logic last);
        int gap;
        gap = gapless ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample_re <= re;
        i_sample_im <= im;
        i_block_end <= last;
        do @(posedge i_clk); while (o_stall);
        sb.note_sample(re, im, last);
    endtask

    // mix of full range, moderate, small, edge and near-clip values for the current gain
    function logic [31:0] pick_component();
        logic [63:0] t;
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom_range(0, 32'h2000_0000);
            2: begin
                t = (sb.gain_q412 == 0)
                    ? 64'(iqgq_pkg::Q_ONE)
                    : (64'(iqgq_pkg::Q_ONE) << GAIN_FRAC) / sb.gain_q412;
                t = t + $urandom_range(0, 8) - 4;
                v = (t > 64'(iqgq_pkg::MAG_MAX)) ? 32'(iqgq_pkg::MAG_MAX) : t[31:0];
            end
            3: case ($urandom_range(0, 4))
                0: v = 32'h0000_0000;
                1: v = 32'h7FFF_FFFF;
                2: v = 32'h8000_0000;
                3: v = 32'h0000_0001;
                default: v = 32'hFFFF_FFFF;
            endcase
            default: v = $urandom_range(0, 255);
        endcase
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    task drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // receiver: random hold-offs, two long ones to back up the pipeline
    initial begin
        int hold;
        t_iq_result got;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (results_seen == 250 || results_seen == 600)
                hold = HOLD_OFF;
            else if ((results_seen / 50) % 4 == 3)
                hold = 0;
            else
                hold = $urandom_range(0, 8);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            got.re    = o_quant_re;
            got.im    = o_quant_im;
            got.peak  = o_peak_magnitude;
            got.clips = o_clipped_count;
            got.comps = o_component_count;
            got.last  = o_block_end_out;
            sb.check_result(got);
            results_seen++;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("** iq_gain_quantizer_with_clip_stats_core: FAILED **");
                $finish;
            end else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_sample_re <= '0;
        i_sample_im <= '0;
        i_block_end <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= iqgq_pkg::CFG_OUT_FORMAT;
        i_cfg_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset format and gain, tracking on (upper data bits ignored)
        cfg_write(iqgq_pkg::CFG_TRACK_CLIPS, 16'hFFFF);
        send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_sample(32'h1000_0000, 32'hF000_0000, 1'b0);  // exactly +/-1.0
        send_sample(32'h1000_0001, 32'hEFFF_FFFF, 1'b1);  // just past 1.0
        send_sample(32'h0FFF_FFFF, 32'hF000_0001, 1'b0);
        send_sample(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_sample(32'h1234_5678, 32'hEDCB_A988, 1'b1);
        send_sample(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        send_sample(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        send_sample(32'h0000_0000, 32'h8000_0001, 1'b0);
        send_sample(32'h0800_0000, 32'hF800_0000, 1'b1);
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: cfg_write(iqgq_pkg::CFG_OUT_FORMAT, 16'(iqgq_pkg::FMT_INT32));
                1: begin
                    cfg_write(iqgq_pkg::CFG_OUT_FORMAT, 16'(iqgq_pkg::FMT_INT16));
                    cfg_write(iqgq_pkg::CFG_GAIN, 16'hFFFF);
                end
                2: begin
                    cfg_write(iqgq_pkg::CFG_OUT_FORMAT, 16'(iqgq_pkg::FMT_INT8));
                    cfg_write(iqgq_pkg::CFG_GAIN, 16'h0000);
                end
                3: begin
                    // format field takes the low two bits only
                    cfg_write(iqgq_pkg::CFG_OUT_FORMAT, 16'hFFFF);
                    cfg_write(iqgq_pkg::CFG_GAIN, 16'd2048);
                    cfg_write(iqgq_pkg::CFG_TRACK_CLIPS, 16'hFFFE);
                    cfg_write(CFG_UNUSED, 16'hA5A5);
                end
                4: begin
                    cfg_write(iqgq_pkg::CFG_OUT_FORMAT, 16'(iqgq_pkg::FMT_INT32));
                    cfg_write(iqgq_pkg::CFG_GAIN, 16'($urandom_range(0, 16'hFFFF)));
                    cfg_write(iqgq_pkg::CFG_TRACK_CLIPS, 16'h0001);
                end
                5: begin
                    cfg_write(iqgq_pkg::CFG_OUT_FORMAT, 16'(iqgq_pkg::FMT_INT16));
                    cfg_write(iqgq_pkg::CFG_GAIN, 16'h0001);
                end
                6: begin
                    cfg_write(iqgq_pkg::CFG_OUT_FORMAT, 16'(iqgq_pkg::FMT_INT8));
                    cfg_write(iqgq_pkg::CFG_GAIN, 16'd8192);
                    cfg_write(iqgq_pkg::CFG_TRACK_CLIPS, 16'h0000);
                end
                default: begin
                    cfg_write(iqgq_pkg::CFG_OUT_FORMAT, 16'(FMT_UNUSED));
                    cfg_write(iqgq_pkg::CFG_GAIN, 16'($urandom_range(0, 16'hFFFF)));
                    cfg_write(iqgq_pkg::CFG_TRACK_CLIPS, 16'h0001);
                end
            endcase
            gapless = (p % 3 == 2);
            repeat (105)
                send_sample(pick_component(), pick_component(), $urandom_range(0, 7) == 0);
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("** iq_gain_quantizer_with_clip_stats_core: PASSED **");
        else
            $display("** iq_gain_quantizer_with_clip_stats_core: FAILED **");
        $finish;
    end

endmodule
